FILE: hdl/lnpe_pkg.sv
// Shared types, codes and constants of the LED notification pattern engine.
package lnpe_pkg;

    // Divider geometry: 26-bit dividend, 16-bit divisor, two quotient bits per cycle
    localparam int DVD_W      = 26;
    localparam int DVS_W      = 16;
    localparam int DIV_STEPS  = DVD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int PER_W      = 14;

    // Command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_ENDED  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Pattern codes
    localparam logic [2:0] PAT_STEADY  = 3'd0;
    localparam logic [2:0] PAT_BLINK   = 3'd1;
    localparam logic [2:0] PAT_BREATHE = 3'd2;
    localparam logic [2:0] PAT_DOUBLE  = 3'd3;
    localparam logic [2:0] PAT_HEART   = 3'd4;
    localparam logic [2:0] PAT_SWEEP   = 3'd5;
    localparam logic [2:0] PAT_SLOW    = 3'd6;

    // Configuration register indexes
    localparam logic REG_BRIGHT_LIMIT   = 1'b0;
    localparam logic REG_FRAME_INTERVAL = 1'b1;

    // Start checks
    localparam logic [15:0] MAX_DURATION = 16'd60000;
    localparam logic [15:0] MIN_PERIOD   = 16'd500;
    localparam logic [15:0] MAX_PERIOD   = 16'd10000;

    // Divider operations of the frame sequence
    typedef enum logic [3:0] {
        OP_PH,
        OP_LV2,
        OP_SCALE,
        OP_VAL2,
        OP_Q3,
        OP_Q4,
        OP_LV4,
        OP_VAL4,
        OP_HUE,
        OP_DONE
    } t_div_op;

    // What an accepted word calls for
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_FIXED,
        ACT_DRAW
    } t_action;

    typedef struct packed {
        logic    accept;
        logic    div_start;
        t_div_op op;
        logic    save_ph;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_action    action;
        logic [2:0] pattern;
        logic       div_busy;
    } t_dp_sts;

    function automatic logic [PER_W-1:0] def_period(input logic [2:0] pat);
        logic [PER_W-1:0] per;
        case (pat)
            PAT_STEADY:  per = PER_W'(2000);
            PAT_BLINK:   per = PER_W'(800);
            PAT_BREATHE: per = PER_W'(2000);
            PAT_DOUBLE:  per = PER_W'(1600);
            PAT_HEART:   per = PER_W'(1800);
            PAT_SWEEP:   per = PER_W'(4000);
            PAT_SLOW:    per = PER_W'(2400);
            default:     per = PER_W'(2000);
        endcase
        return per;
    endfunction

endpackage

FILE: hdl/lnpe_div.sv
// Radix-4 restoring divider: two quotient bits per cycle, quotient and remainder held.
module lnpe_div import lnpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0]   w_t1, w_t2;
    logic             w_ge1, w_ge2;
    logic [DVS_W-1:0] w_rem1, n_rem;
    logic [DVD_W-1:0] w_quo1, n_quo;

    always_comb begin
        w_t1   = {r_rem, r_quo[DVD_W-1]};
        w_ge1  = w_t1 >= {1'b0, r_dvs};
        w_rem1 = w_ge1 ? DVS_W'(w_t1 - {1'b0, r_dvs}) : w_t1[DVS_W-1:0];
        w_quo1 = {r_quo[DVD_W-2:0], w_ge1};
        w_t2   = {w_rem1, w_quo1[DVD_W-1]};
        w_ge2  = w_t2 >= {1'b0, r_dvs};
        n_rem  = w_ge2 ? DVS_W'(w_t2 - {1'b0, r_dvs}) : w_t2[DVS_W-1:0];
        n_quo  = {w_quo1[DVD_W-2:0], w_ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/lnpe_dp.sv
// Datapath: configuration, notification state, divider operands, frame shaping, output word.
module lnpe_dp import lnpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_hue,
    input  logic [7:0]  i_sat,
    input  logic [7:0]  i_val,
    input  logic [2:0]  i_pattern,
    input  logic [15:0] i_period,
    input  logic [15:0] i_duration,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_hue,
    output logic [7:0]  o_out_sat,
    output logic [7:0]  o_out_val,
    output logic        o_active
);

    localparam logic [15:0] DBL_ON1_END  = 16'd160;
    localparam logic [15:0] DBL_ON2_BEG  = 16'd320;
    localparam logic [15:0] DBL_ON2_END  = 16'd480;
    localparam logic [15:0] HB_RISE1_END = 16'd150;
    localparam logic [15:0] HB_BEAT1_END = 16'd300;
    localparam logic [15:0] HB_BEAT2_BEG = 16'd420;
    localparam logic [15:0] HB_RISE2_END = 16'd570;
    localparam logic [15:0] HB_BEAT2_END = 16'd720;

    // Configuration
    logic [7:0] r_bright_lim, r_frame_int;

    // Notification state
    logic             r_notifying, n_notifying;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [7:0]       r_gap, n_gap;
    logic [15:0]      r_run_len, n_run_len;
    logic [PER_W-1:0] r_run_per, n_run_per;
    logic [2:0]       r_run_pat, n_run_pat;
    logic [7:0]       r_run_hue, n_run_hue;
    logic [7:0]       r_run_sat, n_run_sat;
    logic [7:0]       r_run_val, n_run_val;
    logic [1:0]       r_kind, n_kind;
    logic [PER_W-1:0] r_ph;

    // Output word
    logic [1:0] r_o_kind;
    logic [7:0] r_o_hue, r_o_sat, r_o_val;
    logic       r_o_active;

    t_action     w_action;
    logic [15:0] w_el_inc;
    logic [7:0]  w_gap_inc;
    logic        w_bad;

    logic [DVD_W-1:0] w_dvd;
    logic [DVS_W-1:0] w_dvs;
    logic             w_div_busy;
    logic [DVD_W-1:0] w_quo;
    logic [DVS_W-1:0] w_rem;

    logic [PER_W-1:0] w_peff, w_ph, w_x;
    logic [PER_W-2:0] w_half;
    logic [15:0]      w_q16;
    logic [DVD_W-1:0] w_lv4_num;
    logic             w_dbl_on;
    logic [7:0]       w_fh, w_fs, w_fv;

    // ---------------- word decode and state update ----------------
    always_comb begin
        w_el_inc  = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
        w_gap_inc = (r_gap == 8'hFF) ? r_gap : r_gap + 8'd1;
        w_bad = (i_duration == '0) || (i_duration > MAX_DURATION) || (i_pattern > PAT_SLOW) ||
                ((i_period != '0) && ((i_pattern == PAT_STEADY) || (i_period < MIN_PERIOD) ||
                                      (i_period > MAX_PERIOD)));

        n_notifying = r_notifying;
        n_elapsed   = r_elapsed;
        n_gap       = r_gap;
        n_run_len   = r_run_len;
        n_run_per   = r_run_per;
        n_run_pat   = r_run_pat;
        n_run_hue   = r_run_hue;
        n_run_sat   = r_run_sat;
        n_run_val   = r_run_val;
        n_kind      = r_kind;
        w_action    = ACT_NONE;

        if (i_cmd.accept) begin
            case (i_command)
                CMD_TICK: begin
                    if (r_notifying) begin
                        n_elapsed = w_el_inc;
                        n_gap     = w_gap_inc;
                        if (w_el_inc >= r_run_len) begin
                            n_notifying = 1'b0;
                            n_kind      = KIND_ENDED;
                            w_action    = ACT_FIXED;
                        end else if (w_gap_inc >= r_frame_int) begin
                            n_gap    = '0;
                            n_kind   = KIND_FRAME;
                            w_action = ACT_DRAW;
                        end
                    end
                end
                CMD_START: begin
                    if (w_bad) begin
                        n_kind   = KIND_REJECT;
                        w_action = ACT_FIXED;
                    end else begin
                        n_notifying = 1'b1;
                        n_run_len   = i_duration;
                        n_elapsed   = '0;
                        n_gap       = '0;
                        n_run_hue   = i_hue;
                        n_run_sat   = i_sat;
                        n_run_val   = (i_val > r_bright_lim) ? r_bright_lim : i_val;
                        n_run_pat   = i_pattern;
                        n_run_per   = (i_period != '0) ? i_period[PER_W-1:0]
                                                       : def_period(i_pattern);
                        n_kind      = KIND_FRAME;
                        w_action    = ACT_DRAW;
                    end
                end
                CMD_CANCEL: begin
                    if (r_notifying) begin
                        n_notifying = 1'b0;
                        n_kind      = KIND_ENDED;
                        w_action    = ACT_FIXED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- divider operands ----------------
    always_comb begin
        w_peff = (r_run_per == '0) ? PER_W'(1) : r_run_per;
        w_half = w_peff[PER_W-1:1];
        w_ph   = i_cmd.save_ph ? w_rem[PER_W-1:0] : r_ph;
        w_x    = (w_ph < {1'b0, w_half}) ? w_ph : w_peff - w_ph;
        w_q16  = w_quo[15:0];

        // heartbeat: two triangular beats, the second at 70 percent
        if (w_q16 < HB_RISE1_END) begin
            w_lv4_num = DVD_W'(w_q16) * DVD_W'(1000);
        end else if (w_q16 < HB_BEAT1_END) begin
            w_lv4_num = DVD_W'(HB_BEAT1_END - w_q16) * DVD_W'(1000);
        end else if (w_q16 >= HB_BEAT2_BEG && w_q16 < HB_RISE2_END) begin
            w_lv4_num = DVD_W'(w_q16 - HB_BEAT2_BEG) * DVD_W'(700);
        end else if (w_q16 >= HB_RISE2_END && w_q16 < HB_BEAT2_END) begin
            w_lv4_num = DVD_W'(HB_BEAT2_END - w_q16) * DVD_W'(700);
        end else begin
            w_lv4_num = '0;
        end

        case (i_cmd.op)
            OP_PH: begin
                w_dvd = DVD_W'(r_elapsed);
                w_dvs = DVS_W'(w_peff);
            end
            OP_LV2: begin
                if (w_half == '0) begin
                    w_dvd = '0;
                    w_dvs = DVS_W'(1);
                end else begin
                    w_dvd = DVD_W'(w_x) * DVD_W'(1000);
                    w_dvs = DVS_W'(w_half);
                end
            end
            OP_SCALE: begin
                w_dvd = DVD_W'(w_q16) * DVD_W'(850);
                w_dvs = DVS_W'(1000);
            end
            OP_VAL2: begin
                w_dvd = DVD_W'(r_run_val) * (DVD_W'(w_q16) + DVD_W'(150));
                w_dvs = DVS_W'(1000);
            end
            OP_Q3: begin
                w_dvd = DVD_W'(w_ph) * DVD_W'(1600);
                w_dvs = DVS_W'(w_peff);
            end
            OP_Q4: begin
                w_dvd = DVD_W'(w_ph) * DVD_W'(1800);
                w_dvs = DVS_W'(w_peff);
            end
            OP_LV4: begin
                w_dvd = w_lv4_num;
                w_dvs = DVS_W'(150);
            end
            OP_VAL4: begin
                w_dvd = DVD_W'(r_run_val) * DVD_W'(w_q16);
                w_dvs = DVS_W'(1000);
            end
            OP_HUE: begin
                w_dvd = DVD_W'(w_ph) * DVD_W'(256);
                w_dvs = DVS_W'(w_peff);
            end
            default: begin
                w_dvd = '0;
                w_dvs = DVS_W'(1);
            end
        endcase
    end

    lnpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // ---------------- frame shaping ----------------
    always_comb begin
        w_dbl_on = (w_q16 < DBL_ON1_END) || (w_q16 >= DBL_ON2_BEG && w_q16 < DBL_ON2_END);
        w_fh = r_run_hue;
        w_fs = r_run_sat;
        w_fv = r_run_val;
        case (r_run_pat)
            PAT_BLINK, PAT_SLOW: begin
                w_fv = (r_ph < {1'b0, w_half}) ? r_run_val : 8'd0;
            end
            PAT_BREATHE, PAT_HEART: begin
                w_fv = w_quo[7:0];
            end
            PAT_DOUBLE: begin
                w_fv = w_dbl_on ? r_run_val : 8'd0;
            end
            PAT_SWEEP: begin
                w_fh = r_run_hue + w_quo[7:0];
                w_fs = 8'hFF;
            end
            default: begin
            end
        endcase
        if (r_kind != KIND_FRAME) begin
            w_fh = '0;
            w_fs = '0;
            w_fv = '0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_lim <= 8'd255;
            r_frame_int  <= 8'd20;
            r_notifying  <= 1'b0;
            r_elapsed    <= '0;
            r_gap        <= '0;
            r_run_len    <= '0;
            r_run_per    <= '0;
            r_run_pat    <= '0;
            r_run_hue    <= '0;
            r_run_sat    <= '0;
            r_run_val    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BRIGHT_LIMIT:   r_bright_lim <= i_cfg_data;
                    REG_FRAME_INTERVAL: r_frame_int  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_notifying <= n_notifying;
            r_elapsed   <= n_elapsed;
            r_gap       <= n_gap;
            r_run_len   <= n_run_len;
            r_run_per   <= n_run_per;
            r_run_pat   <= n_run_pat;
            r_run_hue   <= n_run_hue;
            r_run_sat   <= n_run_sat;
            r_run_val   <= n_run_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (i_cmd.save_ph) begin
            r_ph <= w_rem[PER_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_o_kind   <= r_kind;
            r_o_hue    <= w_fh;
            r_o_sat    <= w_fs;
            r_o_val    <= w_fv;
            r_o_active <= r_notifying;
        end
    end

    assign o_sts.action   = w_action;
    assign o_sts.pattern  = r_run_pat;
    assign o_sts.div_busy = w_div_busy;

    assign o_kind    = r_o_kind;
    assign o_out_hue = r_o_hue;
    assign o_out_sat = r_o_sat;
    assign o_out_val = r_o_val;
    assign o_active  = r_o_active;

    a_frame_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_kind == KIND_FRAME) |=> o_active)
        else $error("colour frame sent while no notification runs");

endmodule

FILE: hdl/lnpe_ctrl.sv
// Controller: input handshake, divider sequencing per pattern, output word handshake.
module lnpe_ctrl import lnpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    t_state  r_state, n_state;
    t_div_op r_op, n_op, w_next;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;

    function automatic t_div_op next_op(input t_div_op op, input logic [2:0] pat);
        t_div_op nxt;
        case (op)
            OP_PH: begin
                case (pat)
                    PAT_BREATHE: nxt = OP_LV2;
                    PAT_DOUBLE:  nxt = OP_Q3;
                    PAT_HEART:   nxt = OP_Q4;
                    PAT_SWEEP:   nxt = OP_HUE;
                    default:     nxt = OP_DONE;
                endcase
            end
            OP_LV2:   nxt = OP_SCALE;
            OP_SCALE: nxt = OP_VAL2;
            OP_Q4:    nxt = OP_LV4;
            OP_LV4:   nxt = OP_VAL4;
            default:  nxt = OP_DONE;
        endcase
        return nxt;
    endfunction

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_next     = next_op(r_op, i_sts.pattern);

        n_state = r_state;
        n_op    = r_op;

        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = 1'b0;
        o_cmd.op        = r_op;
        o_cmd.save_ph   = 1'b0;
        o_cmd.load_out  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept) begin
                    case (i_sts.action)
                        ACT_DRAW:  n_state = S_PREP;
                        ACT_FIXED: n_state = S_EMIT;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                o_cmd.op        = OP_PH;
                n_op            = OP_PH;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_ph = (r_op == OP_PH);
                    if (w_next == OP_DONE) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.op        = w_next;
                        n_op            = w_next;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = o_cmd.load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_PH;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while still busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output word overwritten before it was taken");

    a_fixed_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.action == ACT_FIXED) |=> (r_state == S_EMIT))
        else $error("ended or rejected word not queued for output");

endmodule

FILE: hdl/led_notification_pattern_engine.sv
// Flow: a tick or cancel that causes no word leaves the controller idle; an ended or rejected word
//   goes from idle straight to the output register, a colour frame first runs the phase divide and
//   then each extra divide of its pattern (double flash, sweep 1; heartbeat, breathe 3).
// Throughput: one word at a time; the shared 2-bit-per-cycle divider sets the frame cost. The
//   next word is taken while a finished word waits at the output.
// Reset: synchronous, active low; clears state, sets brightness limit 255 and interval 20.
module led_notification_pattern_engine import lnpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_hue,
    input  logic [7:0]  i_sat,
    input  logic [7:0]  i_val,
    input  logic [2:0]  i_pattern,
    input  logic [15:0] i_period,
    input  logic [15:0] i_duration,
    // result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_hue,
    output logic [7:0]  o_out_sat,
    output logic [7:0]  o_out_val,
    output logic        o_active
);

    // Commands from the controller to the datapath, status back.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller: accept a word while idle, walk the divide chain the pattern asks
    // for, then hold the result until the output register is free.
    lnpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath: update the notification state at acceptance, feed the divider with
    // phase and level operands, shape the frame colour and drive the output word.
    lnpe_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_command  (i_command),
        .i_hue      (i_hue),
        .i_sat      (i_sat),
        .i_val      (i_val),
        .i_pattern  (i_pattern),
        .i_period   (i_period),
        .i_duration (i_duration),
        .o_kind     (o_kind),
        .o_out_hue  (o_out_hue),
        .o_out_sat  (o_out_sat),
        .o_out_val  (o_out_val),
        .o_active   (o_active)
    );

endmodule
